// File: rtl/can_signal_extract_scale_macros.svh
// Assertion macros shared by the signal decode RTL.
`ifndef CAN_SIGNAL_EXTRACT_SCALE_MACROS_SVH
`define CAN_SIGNAL_EXTRACT_SCALE_MACROS_SVH

// Same-cycle implication, checked on clock, quiet during reset.
`define CSX_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on clock, quiet during reset.
`define CSX_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/csx_pkg.sv
// Types, constants and helpers for the CAN signal decode pipeline.
`default_nettype none

package csx_pkg;

   localparam int PAYLOAD_BYTES = 8;
   localparam int PAYLOAD_BITS  = 64;
   localparam logic [6:0] LEN_MAX = 7'd64;

   // bytes at or past PAYLOAD_BYTES read as zero
   localparam logic [PAYLOAD_BITS-1:0] PAYLOAD_MASK =
      {PAYLOAD_BITS{1'b1}} >> (PAYLOAD_BITS - 8 * PAYLOAD_BYTES);

   localparam logic [63:0] PHYS_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] PHYS_MIN = {1'b1, {63{1'b0}}};

   // stage 1 result: raw field plus what the later stages need
   typedef struct packed {
      logic [63:0] raw;
      logic [6:0]  len;
      logic        sgn;
      logic [31:0] scale;
      logic [31:0] offset;
   } csx_field_type;

   // sign/magnitude operands for the multiplier
   typedef struct packed {
      logic [63:0] raw;
      logic [63:0] amag;
      logic        aneg;
      logic [31:0] bmag;
      logic        bneg;
      logic [31:0] offset;
   } csx_mag_type;

   // unsigned 64x32 product and its sign
   typedef struct packed {
      logic [63:0] raw;
      logic [95:0] prod;
      logic        pneg;
      logic [31:0] offset;
   } csx_prod_type;

   // Motorola stream: bit m of the walk (byte m/8, bit 7-m%8) lands at bit 63-m
   function automatic logic [63:0] csx_moto_stream(input logic [63:0] pay);
      logic [63:0] s;
      for (int m = 0; m < 64; m++) begin
         s[m ^ 63] = pay[m ^ 7];
      end
      return s;
   endfunction

endpackage

`default_nettype wire

// File: rtl/csx_extract.sv
// Field extraction and sign/magnitude conversion: two pipeline stages.
`default_nettype none

`include "can_signal_extract_scale_macros.svh"

module csx_extract
   import csx_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [63:0] in_payload,
   input  wire logic [5:0]  in_start_pos,
   input  wire logic [6:0]  in_sig_len,
   input  wire logic        in_intel_order,
   input  wire logic        in_is_signed,
   input  wire logic [31:0] in_scale_q,
   input  wire logic [31:0] in_offset_q,
   output logic             out_valid,
   input  wire logic        out_ready,
   output csx_mag_type      out_data
);

   logic          s1_v_ff, s2_v_ff;
   logic          s1_ce, s2_ce;
   csx_field_type s1_ff, s1_in;
   csx_mag_type   s2_ff, s2_in;

   logic [63:0] pay;
   logic [63:0] intel_f, moto_f;
   logic [5:0]  moto_pos;
   logic [6:0]  len_c;
   logic [6:0]  len_m1;
   logic [63:0] val;
   logic        ext;

   assign s2_ce    = !s2_v_ff || out_ready;
   assign s1_ce    = !s1_v_ff || s2_ce;
   assign in_ready = s1_ce;

   // stage 1: gather the raw field
   always_comb begin
      len_c    = (in_sig_len > LEN_MAX) ? LEN_MAX : in_sig_len;
      pay      = in_payload & PAYLOAD_MASK;
      intel_f  = (pay >> in_start_pos) & ~({64{1'b1}} << len_c);
      moto_pos = {in_start_pos[5:3], ~in_start_pos[2:0]};
      moto_f   = (csx_moto_stream(pay) << moto_pos) >> (LEN_MAX - len_c);
      s1_in.raw    = in_intel_order ? intel_f : moto_f;
      s1_in.len    = len_c;
      s1_in.sgn    = in_is_signed;
      s1_in.scale  = in_scale_q;
      s1_in.offset = in_offset_q;
   end

   // stage 2: sign extension, magnitudes
   always_comb begin
      len_m1 = s1_ff.len - 7'd1;
      ext    = s1_ff.sgn && (s1_ff.len != 7'd0) && (s1_ff.len != LEN_MAX)
               && s1_ff.raw[len_m1[5:0]];
      val    = ext ? (s1_ff.raw | ({64{1'b1}} << s1_ff.len)) : s1_ff.raw;
      s2_in.raw    = s1_ff.raw;
      s2_in.aneg   = s1_ff.sgn && (s1_ff.len != 7'd0) && val[63];
      s2_in.amag   = s2_in.aneg ? (~val + 64'd1) : val;
      s2_in.bneg   = s1_ff.scale[31];
      s2_in.bmag   = s2_in.bneg ? (~s1_ff.scale + 32'd1) : s1_ff.scale;
      s2_in.offset = s1_ff.offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (s1_ce) s1_v_ff <= in_valid;
         if (s2_ce) s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ce) s1_ff <= s1_in;
      if (s2_ce) s2_ff <= s2_in;
   end

   assign out_valid = s2_v_ff;
   assign out_data  = s2_ff;

   `CSX_ASSERT_IMP(a_raw_fits_len, s1_v_ff,
      (s1_ff.raw & ({64{1'b1}} << s1_ff.len)) == 64'd0, "raw field wider than its length")

endmodule

`default_nettype wire

// File: rtl/csx_mul.sv
// 64x32 magnitude multiply: partial products, then combine.
`default_nettype none

module csx_mul
   import csx_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_valid,
   output logic       in_ready,
   input  wire csx_mag_type in_data,
   output logic       out_valid,
   input  wire logic  out_ready,
   output csx_prod_type out_data
);

   logic         s3_v_ff, s4_v_ff;
   logic         s3_ce, s4_ce;
   logic [63:0]  p0_ff, p1_ff;
   logic [63:0]  raw3_ff;
   logic         pneg3_ff;
   logic [31:0]  off3_ff;
   csx_prod_type s4_ff, s4_in;

   assign s4_ce    = !s4_v_ff || out_ready;
   assign s3_ce    = !s3_v_ff || s4_ce;
   assign in_ready = s3_ce;

   always_comb begin
      s4_in.raw    = raw3_ff;
      s4_in.prod   = {32'd0, p0_ff} + {p1_ff, 32'd0};
      s4_in.pneg   = pneg3_ff;
      s4_in.offset = off3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (s3_ce) s3_v_ff <= in_valid;
         if (s4_ce) s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ce) begin
         p0_ff    <= {32'd0, in_data.amag[31:0]}  * {32'd0, in_data.bmag};
         p1_ff    <= {32'd0, in_data.amag[63:32]} * {32'd0, in_data.bmag};
         raw3_ff  <= in_data.raw;
         pneg3_ff <= in_data.aneg ^ in_data.bneg;
         off3_ff  <= in_data.offset;
      end
      if (s4_ce) s4_ff <= s4_in;
   end

   assign out_valid = s4_v_ff;
   assign out_data  = s4_ff;

endmodule

`default_nettype wire

// File: rtl/csx_sat.sv
// Sign apply, offset add and saturation to 64 bits; holds the output register.
`default_nettype none

module csx_sat
   import csx_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   output logic        in_ready,
   input  wire csx_prod_type in_data,
   output logic        out_valid,
   input  wire logic   out_ready,
   output logic [63:0] out_raw,
   output logic [63:0] out_phys,
   output logic        out_sat
);

   logic        s5_v_ff, s6_v_ff;
   logic        s5_ce, s6_ce;
   logic [96:0] sum_in, sum_ff;
   logic [63:0] raw5_ff;
   logic [96:0] pv;
   logic        fits;
   logic [63:0] phys_in, phys_ff, raw6_ff;
   logic        sat_in, sat_ff;

   assign s6_ce    = !s6_v_ff || out_ready;
   assign s5_ce    = !s5_v_ff || s6_ce;
   assign in_ready = s5_ce;

   // exact signed sum, 97 bits cannot overflow
   always_comb begin
      pv     = {1'b0, in_data.prod} ^ {97{in_data.pneg}};
      sum_in = pv + {96'd0, in_data.pneg}
               + {{65{in_data.offset[31]}}, in_data.offset};
   end

   always_comb begin
      fits    = (sum_ff[96:63] == '0) || (sum_ff[96:63] == '1);
      sat_in  = !fits;
      phys_in = fits ? sum_ff[63:0] : (sum_ff[96] ? PHYS_MIN : PHYS_MAX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
      end else begin
         if (s5_ce) s5_v_ff <= in_valid;
         if (s6_ce) s6_v_ff <= s5_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ce) begin
         sum_ff  <= sum_in;
         raw5_ff <= in_data.raw;
      end
      if (s6_ce) begin
         phys_ff <= phys_in;
         sat_ff  <= sat_in;
         raw6_ff <= raw5_ff;
      end
   end

   assign out_valid = s6_v_ff;
   assign out_raw   = raw6_ff;
   assign out_phys  = phys_ff;
   assign out_sat   = sat_ff;

endmodule

`default_nettype wire

// File: rtl/can_signal_extract_scale.sv
// CAN signal decode: raw field extraction and fixed-point scaling, top level.
//
// Decodes one DBC-style signal per beat: the raw field is gathered from the
// 8-byte payload in Intel or Motorola order (bits past the payload read as
// zero), optionally sign-extended, then raw * scale_q + offset_q is formed
// exactly and clipped to signed Q48.16 with a saturation flag. Six register
// stages: extract, sign/magnitude, partial products, product combine, offset
// add, saturate. A new request is taken every cycle unless every stage is
// full and the output is stalled; the 64x32 multiply split into two 32x32
// partial products sets the stage depth. Each stage stalls only when it is
// full and the stage after it cannot take its beat, so bubbles close up and
// the request side stays open while a result waits at the output.
`default_nettype none

`include "can_signal_extract_scale_macros.svh"

module can_signal_extract_scale
   import csx_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [63:0]        req_payload,
   input  wire logic [5:0]         req_start_pos,
   input  wire logic [6:0]         req_sig_len,
   input  wire logic               req_intel_order,
   input  wire logic               req_is_signed,
   input  wire logic signed [31:0] req_scale_q,
   input  wire logic signed [31:0] req_offset_q,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [63:0]             rsp_raw_field,
   output logic signed [63:0]      rsp_phys_value,
   output logic                    rsp_saturated
);

   // extract -> multiply
   logic         mag_valid, mag_ready;
   csx_mag_type  mag_data;
   // multiply -> saturate
   logic         prod_valid, prod_ready;
   csx_prod_type prod_data;
   logic [63:0]  phys;

   csx_extract u_extract (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_valid),
      .in_ready       (req_ready),
      .in_payload     (req_payload),
      .in_start_pos   (req_start_pos),
      .in_sig_len     (req_sig_len),
      .in_intel_order (req_intel_order),
      .in_is_signed   (req_is_signed),
      .in_scale_q     (req_scale_q),
      .in_offset_q    (req_offset_q),
      .out_valid      (mag_valid),
      .out_ready      (mag_ready),
      .out_data       (mag_data)
   );

   csx_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mag_valid),
      .in_ready  (mag_ready),
      .in_data   (mag_data),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_data  (prod_data)
   );

   // last stage is the output register
   csx_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_data   (prod_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_raw   (rsp_raw_field),
      .out_phys  (phys),
      .out_sat   (rsp_saturated)
   );

   assign rsp_phys_value = phys;

   // a clipped result is always one of the two rails
   `CSX_ASSERT_IMP(a_sat_rail, rsp_valid && rsp_saturated,
      (phys == PHYS_MAX) || (phys == PHYS_MIN), "saturated value off the rails")
   // request side closes only with every stage full and the output stalled
   `CSX_ASSERT_IMP(a_full_when_closed, !req_ready, rsp_valid && !rsp_ready,
      "request side closed with room in the pipeline")
   // a full, stalled pipeline stays full: reopens exactly when the output drains
   `CSX_ASSERT_NXT(a_stall_holds, !req_ready, req_ready == rsp_ready,
      "pipeline moved while stalled")

endmodule

`default_nettype wire
